/* rtl/crbc_pkg.sv */
// ----------------------------------------------------------------------------
// crbc_pkg
// Shared constants and helper functions for the cubic root finder.
// ----------------------------------------------------------------------------
package crbc_pkg;

	localparam int IN_W   = 29;   // bracket and root field width
	localparam int CNT_W  = 16;   // iteration counter / limit width
	localparam int TOL_W  = 31;   // tolerance width
	localparam int STAT_W = 3;
	localparam int F_W    = 64;   // width of f(x)

	localparam int DEF_FRAC_BITS = 16;
	localparam int DEF_X_WIDTH   = 32;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_METHOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

	localparam logic [TOL_W-1:0] TOL_RESET   = 31'd65;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd64;

	// method codes
	localparam logic METHOD_BISECT = 1'b0;
	localparam logic METHOD_CHORD  = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_CONVERGED = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_ORDER = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_CHANGE = 3'd2;
	localparam logic [STAT_W-1:0] ST_ZERO_DIV  = 3'd3;
	localparam logic [STAT_W-1:0] ST_LIMIT     = 3'd4;

	// polynomial constants
	localparam logic [F_W-1:0] CUBE_CAP  = 64'h4000_0000_0000_0000;
	localparam int             SQ_COEF   = 10;
	localparam int             OFFSET    = 15000;
	localparam int             CUBE_DIV  = 25;

	// division by 25: 16-bit digits, reciprocal ceil(2^26/25)
	localparam int DIGIT_W  = 16;
	localparam int DIGITS   = F_W / DIGIT_W;
	localparam int REM_W    = 5;
	localparam int DV_W     = REM_W + DIGIT_W;
	localparam int RECIP_W  = 22;
	localparam int RECIP_SH = 26;
	localparam logic [RECIP_W-1:0] RECIP = 22'd2684355;

	localparam int QUEUE_DEPTH = 2;

	function automatic logic [F_W-1:0] mag(input logic signed [F_W-1:0] v);
		mag = v[F_W-1] ? F_W'(-v) : F_W'(v);
	endfunction

	function automatic logic same_sign(input logic signed [F_W-1:0] a,
			input logic signed [F_W-1:0] b);
		same_sign = (a > 0 && b > 0) || (a < 0 && b < 0);
	endfunction

endpackage

/* rtl/crbc_front.sv */
// ----------------------------------------------------------------------------
// crbc_front
// Input stage: takes a bracket, widens it and flags a bad bracket order.
// ----------------------------------------------------------------------------
module crbc_front import crbc_pkg::*; #(
	parameter int X_WIDTH = DEF_X_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IN_W-1:0] lower_bound,
	input  logic signed [IN_W-1:0] upper_bound,
	output logic                   push,
	output logic [2*X_WIDTH:0]     push_data,
	input  logic                   full
);

	logic                      valid_s1;
	logic [2*X_WIDTH:0]        data_s1;
	logic signed [X_WIDTH-1:0] x1;
	logic signed [X_WIDTH-1:0] x2;

	assign x1        = X_WIDTH'(lower_bound);
	assign x2        = X_WIDTH'(upper_bound);
	assign push      = valid_s1 && !full;
	assign in_ready  = !valid_s1 || push;
	assign push_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// {bad order, x1, x2}
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= {(x1 >= x2), x1, x2};
		end
	end

endmodule

/* rtl/crbc_fifo.sv */
// ----------------------------------------------------------------------------
// crbc_fifo
// Short queue between the front and the solver.
// ----------------------------------------------------------------------------
module crbc_fifo import crbc_pkg::*; #(
	parameter int W = 2 * DEF_X_WIDTH + 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

/* rtl/crbc_cubic.sv */
// ----------------------------------------------------------------------------
// crbc_cubic
// Multi-cycle evaluator of f(x) = -x^3/25 + 10x^2 - 15000 in fixed point.
// ----------------------------------------------------------------------------
module crbc_cubic import crbc_pkg::*; #(
	parameter int X_WIDTH   = DEF_X_WIDTH,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [X_WIDTH-1:0] x,
	output logic                      done,
	output logic signed [F_W-1:0]     f
);

	localparam int SQW = (2 * X_WIDTH > F_W) ? 2 * X_WIDTH : F_W;
	localparam int P1W = F_W + X_WIDTH;
	localparam int P2W = FRAC_BITS + X_WIDTH;
	localparam int DCW = $clog2(DIGITS);

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_SQ   = 3'd1;
	localparam logic [2:0] C_PROD = 3'd2;
	localparam logic [2:0] C_CUBE = 3'd3;
	localparam logic [2:0] C_DIV  = 3'd4;
	localparam logic [2:0] C_FIN  = 3'd5;

	logic [2:0]         state_q;
	logic [X_WIDTH-1:0] a_q;
	logic               neg_q;
	logic [F_W-1:0]     sq_q;
	logic [P1W-1:0]     p1_q;
	logic [P2W-1:0]     p2_q;
	logic [F_W-1:0]     dv_q;
	logic [REM_W-1:0]   rem_q;
	logic [DCW-1:0]     dig_q;
	logic               done_q;
	logic signed [F_W-1:0] f_q;

	logic [SQW-1:0]             aa;
	logic [F_W-1:0]             t1;
	logic [F_W-1:0]             t2;
	logic [F_W:0]               csum;
	logic [DV_W-1:0]            dv;
	logic [DV_W+RECIP_W-1:0]    dprod;
	logic [DIGIT_W-1:0]         qd;
	logic [DV_W-1:0]            rd;
	logic [F_W-1:0]             tpos;

	assign aa    = SQW'(a_q) * SQW'(a_q);
	assign t1    = (p1_q > P1W'(CUBE_CAP)) ? CUBE_CAP : p1_q[F_W-1:0];
	assign t2    = F_W'(p2_q >> FRAC_BITS);
	assign csum  = {1'b0, t1} + {1'b0, t2};
	assign dv    = {rem_q, dv_q[F_W-1 -: DIGIT_W]};
	assign dprod = (DV_W + RECIP_W)'(dv) * (DV_W + RECIP_W)'(RECIP);
	assign qd    = DIGIT_W'(dprod >> RECIP_SH);
	assign rd    = dv - DV_W'(qd * DV_W'(CUBE_DIV));
	assign tpos  = neg_q ? dv_q : -dv_q;

	assign done = done_q;
	assign f    = f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: if (start) state_q <= C_SQ;
				C_SQ:   state_q <= C_PROD;
				C_PROD: state_q <= C_CUBE;
				C_CUBE: state_q <= C_DIV;
				C_DIV:  if (dig_q == DCW'(DIGITS - 1)) state_q <= C_FIN;
				C_FIN: begin
					state_q <= C_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				neg_q <= x[X_WIDTH-1];
				a_q   <= x[X_WIDTH-1] ? X_WIDTH'(-x) : X_WIDTH'(x);
			end
			C_SQ: sq_q <= aa[F_W-1:0] >> FRAC_BITS;
			C_PROD: begin
				p1_q <= P1W'(sq_q >> FRAC_BITS) * P1W'(a_q);
				p2_q <= P2W'(sq_q[FRAC_BITS-1:0]) * P2W'(a_q);
			end
			C_CUBE: begin
				dv_q  <= (csum > {1'b0, CUBE_CAP}) ? CUBE_CAP : csum[F_W-1:0];
				rem_q <= '0;
				dig_q <= '0;
			end
			C_DIV: begin
				// one base-2^16 digit of cube / 25 per cycle
				dv_q  <= {dv_q[F_W-DIGIT_W-1:0], qd};
				rem_q <= REM_W'(rd);
				dig_q <= dig_q + 1'b1;
			end
			C_FIN: begin
				f_q <= signed'(sq_q * F_W'(SQ_COEF) + tpos
					- (F_W'(OFFSET) << FRAC_BITS));
			end
			default: ;
		endcase
	end

endmodule

/* rtl/crbc_back.sv */
// ----------------------------------------------------------------------------
// crbc_back
// Solver: bisection or chord iterations on one bracket, result register.
// ----------------------------------------------------------------------------
module crbc_back import crbc_pkg::*; #(
	parameter int X_WIDTH   = DEF_X_WIDTH,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  logic [2*X_WIDTH:0]       q_data,
	output logic                     q_pop,
	input  logic                     method,
	input  logic [TOL_W-1:0]         tolerance,
	input  logic [CNT_W-1:0]         iteration_limit,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [IN_W-1:0]   root,
	output logic [CNT_W-1:0]         iterations,
	output logic [STAT_W-1:0]        status
);

	localparam int DW = F_W + X_WIDTH;
	localparam int PW = 32 + X_WIDTH;
	localparam int SW = $clog2(X_WIDTH);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EV1     = 4'd1;
	localparam logic [3:0] S_EV2     = 4'd2;
	localparam logic [3:0] S_BI_MID  = 4'd3;
	localparam logic [3:0] S_BI_EVAL = 4'd4;
	localparam logic [3:0] S_CH_CHK  = 4'd5;
	localparam logic [3:0] S_CH_MUL1 = 4'd6;
	localparam logic [3:0] S_CH_MUL2 = 4'd7;
	localparam logic [3:0] S_CH_DIV  = 4'd8;
	localparam logic [3:0] S_CH_PT   = 4'd9;
	localparam logic [3:0] S_CH_EVAL = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0]                state_q;
	logic signed [X_WIDTH-1:0] x1_q, x2_q, xi_q, ev_x_q;
	logic signed [F_W-1:0]     f1_q, f2_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [STAT_W-1:0]         st_q;
	logic                      start_q;
	logic [F_W-1:0]            m_q, d_q, r_q;
	logic [X_WIDTH-1:0]        w_q, dd_q, q_q;
	logic [PW-1:0]             plo_q;
	logic [SW-1:0]             step_q;
	logic                      out_valid_q;
	logic signed [IN_W-1:0]    root_q;
	logic [CNT_W-1:0]          iter_q;
	logic [STAT_W-1:0]         status_q;

	logic                      cub_done;
	logic signed [F_W-1:0]     cub_f;
	logic                      in_bad;
	logic signed [X_WIDTH-1:0] in_x1, in_x2;
	logic signed [X_WIDTH:0]   mid_sum;
	logic                      fi_same;
	logic signed [X_WIDTH-1:0] nx1, nx2;
	logic signed [F_W-1:0]     width;
	logic [F_W-1:0]            d_sum;
	logic [DW-1:0]             prod;
	logic [F_W:0]              r2;
	logic                      ge;
	logic [F_W:0]              r2d;

	assign {in_bad, in_x1, in_x2} = q_data;
	assign q_pop   = (state_q == S_IDLE) && q_valid;
	assign mid_sum = (X_WIDTH + 1)'(x1_q) + (X_WIDTH + 1)'(x2_q);
	assign fi_same = same_sign(cub_f, f1_q);
	assign nx1     = fi_same ? xi_q : x1_q;
	assign nx2     = fi_same ? x2_q : xi_q;
	assign width   = F_W'(nx2) - F_W'(nx1);
	assign d_sum   = mag(f1_q) + mag(f2_q);
	assign prod    = DW'(plo_q) + (DW'(m_q[F_W-1:32] * PW'(w_q)) << 32);
	assign r2      = {r_q, dd_q[X_WIDTH-1]};
	assign ge      = (r2 >= {1'b0, d_q});
	assign r2d     = r2 - {1'b0, d_q};

	assign out_valid  = out_valid_q;
	assign root       = root_q;
	assign iterations = iter_q;
	assign status     = status_q;

	crbc_cubic #(
		.X_WIDTH   (X_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_cubic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.x      (ev_x_q),
		.done   (cub_done),
		.f      (cub_f)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					if (in_bad) begin
						state_q <= S_DONE;
					end else begin
						start_q <= 1'b1;
						state_q <= S_EV1;
					end
				end
				S_EV1: if (cub_done) begin
					start_q <= 1'b1;
					state_q <= S_EV2;
				end
				S_EV2: if (cub_done) begin
					if (same_sign(f1_q, cub_f)) begin
						state_q <= S_DONE;
					end else if (method == METHOD_BISECT) begin
						state_q <= S_BI_MID;
					end else begin
						state_q <= S_CH_CHK;
					end
				end
				S_BI_MID: begin
					start_q <= 1'b1;
					state_q <= S_BI_EVAL;
				end
				S_BI_EVAL: if (cub_done) begin
					if (cub_f == '0 || width < F_W'(tolerance)
						|| cnt_q >= iteration_limit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_BI_MID;
					end
				end
				S_CH_CHK:  state_q <= (d_sum == '0) ? S_DONE : S_CH_MUL1;
				S_CH_MUL1: state_q <= S_CH_MUL2;
				S_CH_MUL2: state_q <= S_CH_DIV;
				S_CH_DIV:  if (step_q == SW'(X_WIDTH - 1)) state_q <= S_CH_PT;
				S_CH_PT: begin
					start_q <= 1'b1;
					state_q <= S_CH_EVAL;
				end
				S_CH_EVAL: if (cub_done) begin
					if (mag(cub_f) < F_W'(tolerance) || cnt_q >= iteration_limit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CH_CHK;
					end
				end
				S_DONE: if (!out_valid_q || out_ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x1_q   <= in_x1;
				x2_q   <= in_x2;
				ev_x_q <= in_x1;
				xi_q   <= '0;
				cnt_q  <= '0;
				st_q   <= ST_BAD_ORDER;
			end
			S_EV1: if (cub_done) begin
				f1_q   <= cub_f;
				ev_x_q <= x2_q;
			end
			S_EV2: if (cub_done) begin
				f2_q <= cub_f;
				st_q <= ST_NO_CHANGE;
			end
			S_BI_MID: begin
				xi_q   <= X_WIDTH'(mid_sum >>> 1);
				ev_x_q <= X_WIDTH'(mid_sum >>> 1);
				cnt_q  <= cnt_q + 1'b1;
			end
			S_BI_EVAL: if (cub_done) begin
				x1_q <= nx1;
				x2_q <= nx2;
				if (fi_same) f1_q <= cub_f;
				// exact zero and narrow bracket both count as converged
				st_q <= (cub_f == '0 || width < F_W'(tolerance)) ? ST_CONVERGED : ST_LIMIT;
			end
			S_CH_CHK: begin
				m_q  <= mag(f1_q);
				d_q  <= d_sum;
				w_q  <= X_WIDTH'(F_W'(x2_q) - F_W'(x1_q));
				st_q <= ST_ZERO_DIV;
			end
			S_CH_MUL1: plo_q <= PW'(m_q[31:0]) * PW'(w_q);
			S_CH_MUL2: begin
				// quotient is at most w, so the high part already sits below d
				r_q    <= prod[DW-1:X_WIDTH];
				dd_q   <= prod[X_WIDTH-1:0];
				q_q    <= '0;
				step_q <= '0;
			end
			S_CH_DIV: begin
				r_q    <= ge ? r2d[F_W-1:0] : r2[F_W-1:0];
				dd_q   <= dd_q << 1;
				q_q    <= {q_q[X_WIDTH-2:0], ge};
				step_q <= step_q + 1'b1;
			end
			S_CH_PT: begin
				xi_q   <= x1_q + signed'(q_q);
				ev_x_q <= x1_q + signed'(q_q);
				cnt_q  <= cnt_q + 1'b1;
			end
			S_CH_EVAL: if (cub_done) begin
				if (fi_same) begin
					x1_q <= xi_q;
					f1_q <= cub_f;
				end else begin
					x2_q <= xi_q;
					f2_q <= cub_f;
				end
				st_q <= (mag(cub_f) < F_W'(tolerance)) ? ST_CONVERGED : ST_LIMIT;
			end
			S_DONE: if (!out_valid_q || out_ready) begin
				root_q   <= IN_W'(xi_q);
				iter_q   <= cnt_q;
				status_q <= st_q;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/cubic_root_bisection_chord.sv */
// ----------------------------------------------------------------------------
// cubic_root_bisection_chord
// Root finder for f(x) = -x^3/25 + 10x^2 - 15000 over a Q13.16 bracket.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes a bracket lower_bound, upper_bound.
// Output channel (out_valid/out_ready) returns root, iterations and status
// (converged, bad order, no sign change, zero divisor, limit reached).
// Configuration: cfg_we with cfg_index 0 method (0 bisection, 1 chord),
// 1 tolerance, 2 iteration_limit; other indexes are ignored. Write only while
// the block is idle.
// The front registers and classifies brackets into a two-entry queue; the
// solver takes one bracket at a time. Each f(x) runs in the shared
// evaluator (square, products, four digits of the divide by 25). A chord
// step forms its point with a serial quotient, one bit per cycle. An item
// with a good order costs two evaluations plus its iterations, up to
// iteration_limit of them (a limit of 0 acts as 1).
// Reset clears the queue, the solver and the output, and loads method 0,
// tolerance 65 and limit 64. A stalled output holds its result; the solver
// waits for it and the queue keeps taking new brackets until it fills.
// ----------------------------------------------------------------------------
module cubic_root_bisection_chord import crbc_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int X_WIDTH   = DEF_X_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IN_W-1:0] lower_bound,
	input  logic signed [IN_W-1:0] upper_bound,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [IN_W-1:0] root,
	output logic [CNT_W-1:0]       iterations,
	output logic [STAT_W-1:0]      status,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [TOL_W-1:0]       cfg_data
);

	localparam int QW = 2 * X_WIDTH + 1;

	logic             method_q;
	logic [TOL_W-1:0] tol_q;
	logic [CNT_W-1:0] limit_q;

	logic          push, full, pop, not_empty;
	logic [QW-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_BISECT;
			tol_q    <= TOL_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_METHOD: method_q <= cfg_data[0];
				REG_TOL:    tol_q    <= cfg_data;
				REG_LIMIT:  limit_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	crbc_front #(
		.X_WIDTH (X_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	crbc_fifo #(
		.W (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	crbc_back #(
		.X_WIDTH   (X_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (not_empty),
		.q_data          (pop_data),
		.q_pop           (pop),
		.method          (method_q),
		.tolerance       (tol_q),
		.iteration_limit (limit_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.root            (root),
		.iterations      (iterations),
		.status          (status)
	);

endmodule

/* sim/tb_cubic_root_bisection_chord.sv */
// ----------------------------------------------------------------------------
// tb_cubic_root_bisection_chord
// Self-checking bench for the bisection / chord root finder.
// Brackets are driven through a valid/ready channel with random gaps, and a
// local solver of the cubic predicts root, iteration count and status for
// each accepted bracket. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_cubic_root_bisection_chord;
	import crbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int Q = 65536;              // one unit in Q16.16

	typedef struct packed {
		logic signed [IN_W-1:0] root;
		logic [CNT_W-1:0]       iters;
		logic [STAT_W-1:0]      stat;
	} solution_t;

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   in_valid = 0;
	logic                   in_ready;
	logic signed [IN_W-1:0] lower_bound = '0;
	logic signed [IN_W-1:0] upper_bound = '0;
	logic                   out_valid;
	logic                   out_ready = 0;
	logic signed [IN_W-1:0] root;
	logic [CNT_W-1:0]       iterations;
	logic [STAT_W-1:0]      status;
	logic                   cfg_we = 0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [TOL_W-1:0]       cfg_data = '0;

	// mirrored register state
	logic             use_chord = METHOD_BISECT;
	logic [TOL_W-1:0] tol_q = TOL_RESET;
	logic [CNT_W-1:0] max_iter = LIMIT_RESET;

	solution_t pending_q[$];
	int        errors = 0;
	int        idle_cycles = 0;
	int        hold_len = 0;
	bit        no_gaps = 0;

	cubic_root_bisection_chord dut (.*);

	always #6 clk = ~clk;

	function automatic logic signed [63:0] cubic_f(input logic signed [63:0] x);
		logic [63:0] a, sq, hi_part, cube, t;
		a = x < 0 ? -x : x;
		sq = (a * a) >> 16;
		hi_part = sq >> 16;
		if (hi_part != 0 && a > CUBE_CAP / hi_part)
			hi_part = CUBE_CAP;
		else begin
			hi_part = hi_part * a;
			if (hi_part > CUBE_CAP)
				hi_part = CUBE_CAP;
		end
		cube = hi_part + (((sq & 64'hFFFF) * a) >> 16);
		if (cube > CUBE_CAP)
			cube = CUBE_CAP;
		t = cube / 25;
		return $signed(sq * 10) + (x < 0 ? $signed(t) : -$signed(t))
			- (64'sd15000 <<< 16);
	endfunction

	function automatic bit agree(input logic signed [63:0] a, b);
		return (a > 0 && b > 0) || (a < 0 && b < 0);
	endfunction

	function automatic solution_t solve_bracket(input logic signed [IN_W-1:0] lo, hi);
		logic signed [63:0] x1, x2, f1, f2, xi, fi;
		logic [63:0] m, d, fmag;
		logic [127:0] quo;
		int unsigned n;
		logic [STAT_W-1:0] st;
		bit done;
		solution_t r;
		x1 = lo;
		x2 = hi;
		xi = 0;
		n = 0;
		done = 0;
		st = ST_CONVERGED;
		if (x1 >= x2)
			st = ST_BAD_ORDER;
		else begin
			f1 = cubic_f(x1);
			f2 = cubic_f(x2);
			if (agree(f1, f2))
				st = ST_NO_CHANGE;
			else if (use_chord == METHOD_BISECT) begin
				while (!done) begin
					n++;
					xi = (x1 + x2) >>> 1;
					fi = cubic_f(xi);
					if (fi == 0) begin
						st = ST_CONVERGED;
						done = 1;
					end else begin
						if (agree(fi, f1)) begin
							x1 = xi;
							f1 = fi;
						end else
							x2 = xi;
						if (x2 - x1 < $signed({33'b0, tol_q})) begin
							st = ST_CONVERGED;
							done = 1;
						end else if (n >= max_iter) begin
							st = ST_LIMIT;
							done = 1;
						end
					end
				end
			end else begin
				while (!done) begin
					m = f1 < 0 ? -f1 : f1;
					d = m + (f2 < 0 ? -f2 : f2);
					if (d == 0) begin
						st = ST_ZERO_DIV;
						done = 1;
					end else begin
						n++;
						quo = ({64'b0, m} * {64'b0, 64'(x2 - x1)}) / {64'b0, d};
						xi = x1 + $signed(quo[63:0]);
						fi = cubic_f(xi);
						if (agree(f1, fi)) begin
							x1 = xi;
							f1 = fi;
						end else begin
							x2 = xi;
							f2 = fi;
						end
						fmag = fi < 0 ? -fi : fi;
						if (fmag < {33'b0, tol_q}) begin
							st = ST_CONVERGED;
							done = 1;
						end else if (n >= max_iter) begin
							st = ST_LIMIT;
							done = 1;
						end
					end
				end
			end
		end
		r.root = xi[IN_W-1:0];
		r.iters = n[CNT_W-1:0];
		r.stat = st;
		return r;
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_bracket(input logic signed [IN_W-1:0] lo, hi);
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat (gap_len() - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1;
		lower_bound = lo;
		upper_bound = hi;
		do @(posedge clk); while (!in_ready);
		pending_q.push_back(solve_bracket(lo, hi));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_METHOD: use_chord = val[0];
			REG_TOL:    tol_q = val;
			REG_LIMIT:  max_iter = val[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 0;
	endtask

	// bracket around one of the three roots (near -36, 42 and 244; centred on -36, 42 and 248)
	task automatic send_good();
		int c;
		int r;
		c = $urandom_range(0, 2);
		r = c == 0 ? -36 * Q : (c == 1 ? 42 * Q : 248 * Q);
		send_bracket(r - int'($urandom_range(1, 16 * Q)), r + int'($urandom_range(1, 16 * Q)));
	endtask

	task automatic send_noise();
		send_bracket(IN_W'($urandom), IN_W'($urandom));
	endtask

	task automatic test_bisection_directed();
		send_bracket(-40 * Q, -30 * Q);
		send_bracket(40 * Q, 45 * Q);
		send_bracket(240 * Q, 250 * Q);
		send_bracket(5 * Q, 5 * Q);              // equal ends
		send_bracket(45 * Q, 40 * Q);            // reversed
		send_bracket(0, 10 * Q);                 // no sign change
		send_bracket(-(1 <<< 27), 1 <<< 27);
		send_bracket(-(1 <<< 28), (1 <<< 28) - 1);
		send_bracket((1 <<< 28) - 1, -(1 <<< 28));
		send_bracket(-1, 0);
		drain();
	endtask

	task automatic test_chord_directed();
		write_reg(REG_METHOD, METHOD_CHORD);
		send_bracket(-40 * Q, -30 * Q);
		send_bracket(40 * Q, 45 * Q);
		send_bracket(240 * Q, 250 * Q);
		send_bracket(-(1 <<< 27), 1 <<< 27);
		send_bracket(0, 10 * Q);
		send_bracket(7 * Q, -7 * Q);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_TOL, 31'h7FFF_FFFF);
		send_bracket(40 * Q, 45 * Q);
		send_bracket(-(1 <<< 27), 1 <<< 27);
		drain();
		write_reg(REG_TOL, 0);
		write_reg(REG_LIMIT, 0);                 // acts as a limit of one
		send_bracket(40 * Q, 45 * Q);
		drain();
		write_reg(REG_LIMIT, 1);
		write_reg(REG_TOL, 1);                   // exact zero only
		write_reg(REG_METHOD, METHOD_BISECT);
		send_bracket(240 * Q, 250 * Q);
		drain();
		write_reg(REG_LIMIT, 16'hFFFF);
		write_reg(REG_TOL, TOL_RESET);
		write_reg(REG_UNUSED, 31'h7FFF_FFFF);    // must be ignored
		send_bracket(-40 * Q, -30 * Q);
		send_bracket(-(1 <<< 27), 1 <<< 27);
		send_bracket(240 * Q, 250 * Q);
		drain();
	endtask

	task automatic test_random_phase(input logic meth, input int n_items);
		write_reg(REG_METHOD, meth);
		write_reg(REG_TOL, $urandom_range(0, 3) == 0 ? $urandom_range(0, 31'h7FFF_FFFF)
			: $urandom_range(1, meth == METHOD_CHORD ? 1 << 20 : 4096));
		write_reg(REG_LIMIT, $urandom_range(1, meth == METHOD_CHORD ? 16 : 40));
		no_gaps = $urandom_range(0, 3) == 0;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 9) < 8)
				send_good();
			else
				send_noise();
		end
		drain();
		no_gaps = 0;
	endtask

	task automatic test_backpressure();
		write_reg(REG_METHOD, METHOD_BISECT);
		write_reg(REG_LIMIT, 8);
		@(negedge clk);
		hold_len = 3000;
		no_gaps = 1;
		repeat (12) send_good();
		no_gaps = 0;
		drain();
	endtask

	// result receiver with random stalls
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_ready = 0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
				out_ready = 0;
				repeat (gap_len()) @(negedge clk);
			end
			out_ready = 1;
		end
	end

	always @(posedge clk) begin
		solution_t e;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0)
				report("result transaction with nothing expected");
			else begin
				e = pending_q.pop_front();
				if (root !== e.root)
					report($sformatf("root %0d, expected %0d", root, e.root));
				if (iterations !== e.iters)
					report($sformatf("iterations %0d, expected %0d", iterations, e.iters));
				if (status !== e.stat)
					report($sformatf("status %0d, expected %0d", status, e.stat));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("cubic_root_bisection_chord verification failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		test_bisection_directed();
		test_chord_directed();
		test_register_extremes();
		test_backpressure();
		for (int p = 0; p < 10; p++)
			test_random_phase(p % 2 ? METHOD_CHORD : METHOD_BISECT, p % 2 ? 80 : 140);
		drain();
		repeat (50) @(negedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("cubic_root_bisection_chord verification clean");
		else
			$display("cubic_root_bisection_chord verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/crbc_pkg.sv
rtl/crbc_front.sv
rtl/crbc_fifo.sv
rtl/crbc_cubic.sv
rtl/crbc_back.sv
rtl/cubic_root_bisection_chord.sv
sim/tb_cubic_root_bisection_chord.sv
